// ===== rtl/smac_pkg.sv =====
// Shared types and constants of the shadow memory access checker.
`default_nettype none
package smac_pkg;

    localparam int ADDR_W          = 64;
    localparam int LEN_W           = 16;
    localparam int SHADOW_W        = 8;
    localparam int GRANULE_SHIFT   = 3;
    localparam int SHADOW_ENTRIES_DEF = 4096;
    localparam int PADDR_W         = 4;
    localparam int PDATA_W         = 64;

    localparam logic [1:0] OP_POISON   = 2'd0;
    localparam logic [1:0] OP_UNPOISON = 2'd1;
    localparam logic [1:0] OP_CHECK    = 2'd2;
    localparam logic [1:0] OP_NONE     = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_POISONED = 2'd1;
    localparam logic [1:0] ST_BELOW    = 2'd2;
    localparam logic [1:0] ST_BEYOND   = 2'd3;

    localparam logic REG_REGION_BASE = 1'b0;

    typedef struct packed {
        logic [1:0]          op;
        logic [ADDR_W-1:0]   address;
        logic [LEN_W-1:0]    length;
        logic [SHADOW_W-1:0] poison_value;
        logic                is_store;
    } item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] fault_address;
        logic [LEN_W-1:0]  fault_length;
        logic              fault_is_store;
    } result_t;

endpackage
`default_nettype wire

// ===== rtl/smac_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module smac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/smac_cfg.sv =====
// APB register file holding the region base address.
`default_nettype none
module smac_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [smac_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [smac_pkg::PDATA_W-1:0]  pwdata,
    output logic      [smac_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready,
    output logic      [smac_pkg::ADDR_W-1:0]   region_base
);
    import smac_pkg::*;

    logic [ADDR_W-1:0] region_base_reg;
    logic              sel_base;

    assign sel_base    = (paddr[PADDR_W-1] == REG_REGION_BASE);
    assign pready      = 1'b1;
    assign region_base = region_base_reg;
    assign prdata      = sel_base ? region_base_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_base_reg <= '0;
        end
        else if (psel && penable && pwrite && sel_base)
        begin
            region_base_reg <= pwdata;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/smac_ctrl.sv =====
// Sequencer: shadow clear after reset, address setup, shadow fill, shadow scan and result register.
`default_nettype none
module smac_ctrl #(
    parameter int SHADOW_ENTRIES = smac_pkg::SHADOW_ENTRIES_DEF,
    localparam int IDXW = $clog2(SHADOW_ENTRIES)
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire smac_pkg::item_t                item,
    output logic                                done,
    output smac_pkg::result_t                   result,
    input  wire logic [smac_pkg::ADDR_W-1:0]    region_base,
    output logic                                mem_we,
    output logic      [IDXW-1:0]                mem_waddr,
    output logic      [smac_pkg::SHADOW_W-1:0]  mem_wdata,
    output logic                                mem_re,
    output logic      [IDXW-1:0]                mem_raddr,
    input  wire logic [smac_pkg::SHADOW_W-1:0]  mem_rdata
);
    import smac_pkg::*;

    localparam int CNTW = IDXW + 1;
    localparam int GW   = ADDR_W - GRANULE_SHIFT;
    localparam logic [GW-1:0]   ENTRIES_G = GW'(SHADOW_ENTRIES);
    localparam logic [CNTW-1:0] ENTRIES_C = CNTW'(SHADOW_ENTRIES);
    localparam logic [CNTW-1:0] LAST_C    = CNTW'(SHADOW_ENTRIES - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CALC1 = 3'd2;
    localparam logic [2:0] S_CALC2 = 3'd3;
    localparam logic [2:0] S_CALC3 = 3'd4;
    localparam logic [2:0] S_FILL  = 3'd5;
    localparam logic [2:0] S_SCAN  = 3'd6;

    logic [2:0]        state_reg, state_next;
    item_t             item_reg, item_next;
    logic              below_reg, below_next;
    logic [ADDR_W-1:0] off_reg, off_next;
    logic [ADDR_W-1:0] sum_reg, sum_next;
    logic              ovf_reg, ovf_next;
    logic [CNTW-1:0]   gran_reg, gran_next;
    logic [CNTW-1:0]   limit_reg, limit_next;
    logic [IDXW-1:0]   last_reg, last_next;
    logic              tail_reg, tail_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [IDXW-1:0]   pend_gran_reg, pend_gran_next;
    logic              done_reg, done_next;
    result_t           result_reg, result_next;

    logic [ADDR_W:0]   diff;
    logic [ADDR_W:0]   sum_wide;
    logic [LEN_W-1:0]  add_len;
    logic [GW-1:0]     first_g;
    logic [GW-1:0]     end_g;
    logic [2:0]        end_low;
    logic              hit_fault;

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    assign diff     = {1'b0, item_reg.address} - {1'b0, region_base};
    assign add_len  = (item_reg.op == OP_CHECK) ? (item_reg.length - LEN_W'(1))
                                                : item_reg.length;
    assign sum_wide = {1'b0, off_reg} + {{(ADDR_W + 1 - LEN_W){1'b0}}, add_len};
    assign first_g  = off_reg[ADDR_W-1:GRANULE_SHIFT];
    assign end_g    = sum_reg[ADDR_W-1:GRANULE_SHIFT];
    assign end_low  = item_reg.address[2:0] + item_reg.length[2:0] - 3'd1;
    assign hit_fault = ($signed({5'b0, end_low}) >= $signed(mem_rdata));

    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        below_next      = below_reg;
        off_next        = off_reg;
        sum_next        = sum_reg;
        ovf_next        = ovf_reg;
        gran_next       = gran_reg;
        limit_next      = limit_reg;
        last_next       = last_reg;
        tail_next       = tail_reg;
        pend_valid_next = 1'b0;
        pend_gran_next  = pend_gran_reg;
        done_next       = 1'b0;
        result_next     = result_reg;
        mem_we          = 1'b0;
        mem_waddr       = gran_reg[IDXW-1:0];
        mem_wdata       = '0;
        mem_re          = 1'b0;
        mem_raddr       = gran_reg[IDXW-1:0];

        result_next.fault_address  = item_reg.address;
        result_next.fault_length   = item_reg.length;
        result_next.fault_is_store = item_reg.is_store;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                gran_next = gran_reg + CNTW'(1);
                if (gran_reg == LAST_C)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    item_next  = item;
                    state_next = S_CALC1;
                end
            end
            S_CALC1:
            begin
                off_next   = diff[ADDR_W-1:0];
                below_next = diff[ADDR_W];
                state_next = S_CALC2;
            end
            S_CALC2:
            begin
                sum_next   = sum_wide[ADDR_W-1:0];
                ovf_next   = sum_wide[ADDR_W];
                state_next = S_CALC3;
            end
            S_CALC3:
            begin
                last_next = sum_reg[GRANULE_SHIFT +: IDXW];
                if ((item_reg.length == '0) || (item_reg.op == OP_NONE))
                begin
                    result_next.status = ST_OK;
                    done_next          = 1'b1;
                    state_next         = S_IDLE;
                end
                else if (below_reg)
                begin
                    result_next.status = (item_reg.op == OP_CHECK) ? ST_BELOW : ST_OK;
                    done_next          = 1'b1;
                    state_next         = S_IDLE;
                end
                else if (item_reg.op == OP_CHECK)
                begin
                    if (ovf_reg || (end_g >= ENTRIES_G))
                    begin
                        result_next.status = ST_BEYOND;
                        done_next          = 1'b1;
                        state_next         = S_IDLE;
                    end
                    else
                    begin
                        gran_next  = off_reg[GRANULE_SHIFT +: CNTW];
                        state_next = S_SCAN;
                    end
                end
                else
                begin
                    gran_next  = (first_g >= ENTRIES_G) ? ENTRIES_C
                                                        : off_reg[GRANULE_SHIFT +: CNTW];
                    limit_next = (ovf_reg || (end_g >= ENTRIES_G)) ? ENTRIES_C
                                                                   : sum_reg[GRANULE_SHIFT +: CNTW];
                    tail_next  = (item_reg.op == OP_UNPOISON) &&
                                 (item_reg.length[2:0] != 3'd0) &&
                                 !ovf_reg && (end_g < ENTRIES_G);
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                if (gran_reg < limit_reg)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = (item_reg.op == OP_UNPOISON) ? '0 : item_reg.poison_value;
                    gran_next = gran_reg + CNTW'(1);
                end
                else
                begin
                    if (tail_reg)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = last_reg;
                        mem_wdata = {5'b0, item_reg.length[2:0]};
                    end
                    result_next.status = ST_OK;
                    done_next          = 1'b1;
                    state_next         = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (gran_reg <= {1'b0, last_reg})
                begin
                    mem_re          = 1'b1;
                    pend_valid_next = 1'b1;
                    pend_gran_next  = gran_reg[IDXW-1:0];
                    gran_next       = gran_reg + CNTW'(1);
                end
                if (pend_valid_reg &&
                    ((mem_rdata != '0) || (pend_gran_reg == last_reg)))
                begin
                    if (mem_rdata == '0)
                    begin
                        result_next.status = ST_OK;
                    end
                    else if (pend_gran_reg != last_reg)
                    begin
                        result_next.status = ST_POISONED;
                    end
                    else
                    begin
                        result_next.status = hit_fault ? ST_POISONED : ST_OK;
                    end
                    pend_valid_next = 1'b0;
                    done_next       = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            gran_reg       <= '0;
            pend_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            gran_reg       <= gran_next;
            pend_valid_reg <= pend_valid_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        below_reg     <= below_next;
        off_reg       <= off_next;
        sum_reg       <= sum_next;
        ovf_reg       <= ovf_next;
        limit_reg     <= limit_next;
        last_reg      <= last_next;
        tail_reg      <= tail_next;
        pend_gran_reg <= pend_gran_next;
        result_reg    <= result_next;
    end

endmodule
`default_nettype wire

// ===== rtl/shadow_memory_access_checker_unit.sv =====
// Top level of the shadow memory access checker.
//
//  channel   handshake                          payload
//  --------  ---------------------------------  -----------------------
//  item      start && !busy                     item   (smac_pkg::item_t)
//  result    done, one cycle, no back-pressure  result (smac_pkg::result_t)
//  config    psel && penable && pwrite (APB)    pwdata, paddr[3] selects
//
//  After reset the shadow RAM is cleared one entry a cycle while busy stays
//  high. Every item then passes through the setup states S_CALC1, S_CALC2 and
//  S_CALC3 for the offset and end address. A check scans one granule per cycle
//  with a pipelined RAM read; poison and unpoison write one granule per cycle
//  on the single write port, plus a closing step that also writes a partial
//  tail for unpoison. done pulses the cycle after the last step; busy drops
//  in that same cycle. The result receiver cannot stall.
`default_nettype none
module shadow_memory_access_checker_unit #(
    parameter int SHADOW_ENTRIES = smac_pkg::SHADOW_ENTRIES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire smac_pkg::item_t               item,
    output logic                               done,
    output smac_pkg::result_t                  result,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [smac_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [smac_pkg::PDATA_W-1:0]  pwdata,
    output logic      [smac_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready
);
    import smac_pkg::*;

    localparam int IDXW = $clog2(SHADOW_ENTRIES);

    logic [ADDR_W-1:0]   region_base;
    logic                mem_we;
    logic [IDXW-1:0]     mem_waddr;
    logic [SHADOW_W-1:0] mem_wdata;
    logic                mem_re;
    logic [IDXW-1:0]     mem_raddr;
    logic [SHADOW_W-1:0] mem_rdata;

    smac_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .region_base (region_base)
    );

    smac_ctrl #(
        .SHADOW_ENTRIES (SHADOW_ENTRIES)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .item        (item),
        .done        (done),
        .result      (result),
        .region_base (region_base),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

    smac_ram #(
        .WIDTH (SHADOW_W),
        .DEPTH (SHADOW_ENTRIES)
    ) u_shadow_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule
`default_nettype wire
